>>> rtl/core/pfa_pkg.sv
// Shared widths, request and status codes, state type and control structs of the allocator.
`default_nettype none

package pfa_pkg;

    // Fixed widths of the interface fields
    localparam int REQ_W  = 3;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 16;
    localparam int FREE_W = 11;
    localparam int CFG_W  = 11;

    localparam logic [CFG_W-1:0] PAGE_COUNT_RST = 11'd1024;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FREE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INCREF = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DECREF = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INIT   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOMEM   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NONZERO = 3'd2;
    localparam logic [STAT_W-1:0] ST_FREED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;
    localparam logic [STAT_W-1:0] ST_SAT     = 3'd5;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // latch request, launch memory reads
        logic exec;        // update state and load the result register
        logic sweep;       // write one entry of every memory per cycle
        logic sweep_init;  // sweep writes the init image, else the reset image
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_is_init;
        logic out_free;
        logic sweep_last;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/core/pfa_ctrl.sv
// Controller state machine of the allocator: clearing pass, accept, init sweep, execute.
`default_nettype none

module pfa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire pfa_pkg::t_stat i_stat,
    output pfa_pkg::t_cmd      o_cmd
);
    import pfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.in_is_init ? S_SWEEP : S_EXEC;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.sweep_init = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result register can take the item
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/pfa_dp.sv
// Datapath of the allocator: free stack, page table memory, depth, config and result register.
`default_nettype none

module pfa_dp #(
    parameter int NUM_PAGES = 1024,
    parameter int REF_WIDTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pfa_pkg::t_cmd               i_cmd,
    output pfa_pkg::t_stat                   o_stat,
    input  wire logic                        i_cfg_we,
    input  wire logic [pfa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic [pfa_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [pfa_pkg::IDX_W-1:0]   i_page_index,
    input  wire logic                        i_out_stall,
    output logic                             o_out_valid,
    output logic [pfa_pkg::STAT_W-1:0]       o_status,
    output logic [pfa_pkg::IDX_W-1:0]        o_result_page,
    output logic [pfa_pkg::CNT_W-1:0]        o_ref_count,
    output logic [pfa_pkg::FREE_W-1:0]       o_free_pages
);
    import pfa_pkg::*;

    localparam int PW = $clog2(NUM_PAGES);
    localparam int DW = $clog2(NUM_PAGES + 1);
    localparam int RW = REF_WIDTH;
    localparam int XW = (DW > CFG_W) ? DW : CFG_W;
    localparam logic [RW-1:0] REF_MAX = {RW{1'b1}};

    // Memories: free stack of page numbers, page table of {free mark, count}
    logic [PW-1:0] stk_mem [NUM_PAGES];
    logic [RW:0]   pt_mem  [NUM_PAGES];

    logic [CFG_W-1:0]  r_page_count;
    logic [DW-1:0]     r_depth;
    logic [REQ_W-1:0]  r_req;
    logic [IDX_W-1:0]  r_idx;
    logic [PW-1:0]     r_sweep_ptr;
    logic [PW-1:0]     r_stk_q;
    logic [RW:0]       r_pt_q;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [IDX_W-1:0]  r_page;
    logic [CNT_W-1:0]  r_cnt;
    logic [FREE_W-1:0] r_free;

    logic [XW-1:0]     n_eff;
    logic              in_range;
    logic [PW-1:0]     idx_pw;
    logic [RW-1:0]     cnt_q;
    logic              mark_q;
    logic [RW-1:0]     dec_cnt;
    logic              can_push;

    logic [STAT_W-1:0] e_status;
    logic [IDX_W-1:0]  e_page;
    logic [RW-1:0]     e_cnt;
    logic [DW-1:0]     n_depth;
    logic              e_pt_we;
    logic [PW-1:0]     e_pt_wa;
    logic [RW:0]       e_pt_wd;
    logic              e_stk_we;

    logic              m_pt_we;
    logic [PW-1:0]     m_pt_wa;
    logic [RW:0]       m_pt_wd;
    logic              m_stk_we;
    logic [PW-1:0]     m_stk_wa;
    logic [PW-1:0]     m_stk_wd;
    logic              sw_mark;
    logic [RW-1:0]     sw_cnt;

    assign n_eff    = (XW'(r_page_count) > XW'(NUM_PAGES)) ? XW'(NUM_PAGES)
                                                            : XW'(r_page_count);
    assign in_range = XW'(r_idx) < n_eff;
    assign idx_pw   = PW'(r_idx);
    assign cnt_q    = r_pt_q[RW-1:0];
    assign mark_q   = r_pt_q[RW];
    assign dec_cnt  = (cnt_q == '0) ? '0 : cnt_q - RW'(1);
    assign can_push = r_depth < DW'(NUM_PAGES);

    // Work out one request from the latched fields and the read data
    always_comb begin
        e_status = ST_OK;
        e_page   = r_idx;
        e_cnt    = '0;
        n_depth  = r_depth;
        e_pt_we  = 1'b0;
        e_pt_wa  = idx_pw;
        e_pt_wd  = r_pt_q;
        e_stk_we = 1'b0;
        case (r_req)
            REQ_ALLOC: begin
                if (r_depth == '0) begin
                    e_status = ST_NOMEM;
                    e_page   = '0;
                end else begin
                    n_depth = r_depth - DW'(1);
                    e_page  = IDX_W'(r_stk_q);
                    e_pt_we = 1'b1;
                    e_pt_wa = r_stk_q;
                    e_pt_wd = '0;
                end
            end
            REQ_FREE: begin
                if (!in_range) begin
                    e_status = ST_RANGE;
                end else begin
                    e_cnt = cnt_q;
                    if (mark_q) begin
                        e_status = ST_FREED;
                    end else if (cnt_q != '0) begin
                        e_status = ST_NONZERO;
                    end else if (can_push) begin
                        e_stk_we = 1'b1;
                        e_pt_we  = 1'b1;
                        e_pt_wd  = {1'b1, cnt_q};
                        n_depth  = r_depth + DW'(1);
                    end
                end
            end
            REQ_INCREF: begin
                if (!in_range) begin
                    e_status = ST_RANGE;
                end else if (cnt_q == REF_MAX) begin
                    e_status = ST_SAT;
                    e_cnt    = cnt_q;
                end else begin
                    e_cnt   = cnt_q + RW'(1);
                    e_pt_we = 1'b1;
                    e_pt_wd = {mark_q, cnt_q + RW'(1)};
                end
            end
            REQ_DECREF: begin
                if (!in_range) begin
                    e_status = ST_RANGE;
                end else begin
                    e_cnt   = dec_cnt;
                    e_pt_we = 1'b1;
                    e_pt_wd = {mark_q, dec_cnt};
                    if (dec_cnt == '0) begin
                        if (mark_q) begin
                            e_status = ST_FREED;
                        end else if (can_push) begin
                            e_stk_we = 1'b1;
                            e_pt_wd  = {1'b1, dec_cnt};
                            n_depth  = r_depth + DW'(1);
                        end
                    end
                end
            end
            REQ_INIT: begin
                e_page  = '0;
                e_cnt   = RW'(1);
                n_depth = (n_eff >= XW'(2)) ? DW'(n_eff - XW'(1)) : '0;
            end
            default: begin
                e_cnt = in_range ? cnt_q : '0;
            end
        endcase
    end

    // Init sweep image: page 0 reserved with count one, pages 1..n-1 marked free; else page table cleared
    assign sw_cnt  = (i_cmd.sweep_init && r_sweep_ptr == '0) ? RW'(1) : '0;
    assign sw_mark = i_cmd.sweep_init && (r_sweep_ptr != '0)
                     && (XW'(r_sweep_ptr) < n_eff);

    always_comb begin
        if (i_cmd.sweep) begin
            m_pt_we  = 1'b1;
            m_pt_wa  = r_sweep_ptr;
            m_pt_wd  = {sw_mark, sw_cnt};
            m_stk_we = 1'b1;
            m_stk_wa = r_sweep_ptr;
            m_stk_wd = r_sweep_ptr + PW'(1);
        end else begin
            m_pt_we  = i_cmd.exec && e_pt_we;
            m_pt_wa  = e_pt_wa;
            m_pt_wd  = e_pt_wd;
            m_stk_we = i_cmd.exec && e_stk_we;
            m_stk_wa = PW'(r_depth);
            m_stk_wd = idx_pw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_pt_we) begin
            pt_mem[m_pt_wa] <= m_pt_wd;
        end
        if (m_stk_we) begin
            stk_mem[m_stk_wa] <= m_stk_wd;
        end
    end

    // Registered reads, launched with the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pt_q  <= pt_mem[PW'(i_page_index)];
            r_stk_q <= stk_mem[PW'(r_depth - DW'(1))];
            r_req   <= i_req_type;
            r_idx   <= i_page_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= PAGE_COUNT_RST;
            r_depth      <= '0;
            r_sweep_ptr  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_page_count <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_depth <= n_depth;
            end
            if (i_cmd.sweep) begin
                r_sweep_ptr <= o_stat.sweep_last ? '0 : r_sweep_ptr + PW'(1);
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= e_status;
            r_page   <= e_page;
            r_cnt    <= CNT_W'(e_cnt);
            r_free   <= FREE_W'(n_depth);
        end
    end

    assign o_stat.in_is_init = (i_req_type == REQ_INIT);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.sweep_last = (r_sweep_ptr == PW'(NUM_PAGES - 1));

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_result_page = r_page;
    assign o_ref_count   = r_cnt;
    assign o_free_pages  = r_free;

endmodule

`default_nettype wire

>>> rtl/core/page_frame_allocator_refcount.sv
// Top level of the page frame allocator with LIFO free list and reference counts.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  request | in        | i_in_valid / o_in_stall  | i_req_type, i_page_index
//  result  | out       | o_out_valid / i_out_stall| o_status, o_result_page, o_ref_count,
//          |           |                         | o_free_pages
//  config  | in        | i_cfg_we                | i_cfg_wdata (page_count)
//
// Alloc, free, incref, decref and the other codes run as an accept with the memory
// reads, then one read-modify-write of the page table and free stack memories.
// Init adds a sweep before execute that writes one entry of each memory per cycle.
// After reset a clearing pass over every entry runs before the first item is taken.
// A stalled result holds in the output register; the next item is still accepted and
// waits at the execute step until the register frees.
`default_nettype none

module page_frame_allocator_refcount #(
    parameter int NUM_PAGES = 1024,
    parameter int REF_WIDTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pfa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [pfa_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [pfa_pkg::IDX_W-1:0]   i_page_index,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [pfa_pkg::STAT_W-1:0]       o_status,
    output logic [pfa_pkg::IDX_W-1:0]        o_result_page,
    output logic [pfa_pkg::CNT_W-1:0]        o_ref_count,
    output logic [pfa_pkg::FREE_W-1:0]       o_free_pages
);
    import pfa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pfa_dp #(
        .NUM_PAGES (NUM_PAGES),
        .REF_WIDTH (REF_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_page_index  (i_page_index),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_result_page (o_result_page),
        .o_ref_count   (o_ref_count),
        .o_free_pages  (o_free_pages)
    );

    a_exec_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> stat.out_free)
        else $error("result loaded while output register is held");

    a_exec_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_out_valid)
        else $error("executed item produced no result");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((cmd.accept && cmd.exec) || (cmd.accept && cmd.sweep) || (cmd.exec && cmd.sweep)))
        else $error("overlapping controller commands");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_free_pages) <= NUM_PAGES))
        else $error("free list depth beyond page count");

endmodule

`default_nettype wire
